@@ src/assert_macros.svh @@
// Assertion macros shared by the encoder modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ src/ifpe_pkg.sv @@
// Shared types and constants for the IR frame pulse encoder.
// No dependencies; imported by every encoder module.
package ifpe_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int POS_W       = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;

  localparam int DUR_W  = 16;
  localparam int SUM_W  = DUR_W + 1;
  localparam int NREG   = 8;
  localparam int IDX_W  = 3;

  localparam logic [SUM_W-1:0] FIRST_MARK_BONUS   = SUM_W'(40);
  localparam logic [SUM_W-1:0] NIBBLE_SPACE_BONUS = SUM_W'(70);
  localparam logic [SUM_W-1:0] AFTER_ONE_BONUS    = SUM_W'(30);
  localparam logic [3:0]       NIBBLE_MASK        = 4'b1111;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZERO_MARK    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ONE_MARK     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_FOOTER_MARK  = 3'd6;
  localparam logic [IDX_W-1:0] REG_FOOTER_SPACE = 3'd7;

  // pair slots within one byte
  localparam logic [3:0] SLOT_HEAD  = 4'd0;
  localparam logic [3:0] SLOT_BIT0  = 4'd1;
  localparam logic [3:0] SLOT_BIT7  = 4'd8;
  localparam logic [3:0] SLOT_FOOT  = 4'd9;
  localparam logic [3:0] SLOT_TRAIL = 4'd10;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark;
    logic [DUR_W-1:0] header_space;
    logic [DUR_W-1:0] zero_mark;
    logic [DUR_W-1:0] zero_space;
    logic [DUR_W-1:0] one_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] footer_mark;
    logic [DUR_W-1:0] footer_space;
  } cfg_t;

  // one byte held for pair generation
  typedef struct packed {
    logic [7:0] byte_val;   // upper nibble already replaced on the last byte
    logic       first;
    logic       last;
    logic       prev_bit;   // last bit sent before this byte
  } item_t;

endpackage

@@ src/ifpe_cfg.sv @@
// Configuration register file: eight 16-bit durations.
// Depends on ifpe_pkg.
module ifpe_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [ifpe_pkg::IDX_W-1:0] cfg_index,
  input  logic [ifpe_pkg::DUR_W-1:0] cfg_wdata,
  output ifpe_pkg::cfg_t             cfg
);
  import ifpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_HEADER_MARK:  cfg.header_mark  <= cfg_wdata;
        REG_HEADER_SPACE: cfg.header_space <= cfg_wdata;
        REG_ZERO_MARK:    cfg.zero_mark    <= cfg_wdata;
        REG_ZERO_SPACE:   cfg.zero_space   <= cfg_wdata;
        REG_ONE_MARK:     cfg.one_mark     <= cfg_wdata;
        REG_ONE_SPACE:    cfg.one_space    <= cfg_wdata;
        REG_FOOTER_MARK:  cfg.footer_mark  <= cfg_wdata;
        REG_FOOTER_SPACE: cfg.footer_space <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ src/ifpe_input.sv @@
// Input register and frame state: byte position, nibble checksum, last bit.
// Depends on ifpe_pkg and assert_macros.svh.
module ifpe_input (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      frame_byte,
  output logic            item_valid,
  output ifpe_pkg::item_t item,
  input  logic            item_done
);
  import ifpe_pkg::*;
  `include "assert_macros.svh"

  logic [POS_W-1:0] byte_position;
  logic [3:0]       nibble_sum;
  logic             previous_bit;
  logic             accept;
  logic             is_first;
  logic             is_last;
  logic [3:0]       lo;
  logic [3:0]       hi;
  logic [3:0]       check;

  assign in_ready = !item_valid || item_done;
  assign accept   = in_valid && in_ready;
  assign lo       = frame_byte[3:0];
  assign hi       = frame_byte[7:4];
  assign is_first = (byte_position == '0);
  assign is_last  = (byte_position == POS_W'(FRAME_BYTES - 1));
  assign check    = (nibble_sum + lo) & NIBBLE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      byte_position <= '0;
      nibble_sum    <= '0;
      previous_bit  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (item_done) begin
        item_valid <= 1'b0;
      end
      if (accept) begin
        if (is_last) begin
          byte_position <= '0;
          nibble_sum    <= '0;
          previous_bit  <= 1'b0;
        end else begin
          byte_position <= byte_position + 1'b1;
          nibble_sum    <= nibble_sum + lo + hi;
          previous_bit  <= frame_byte[7];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.byte_val <= is_last ? {check, lo} : frame_byte;
      item.first    <= is_first;
      item.last     <= is_last;
      item.prev_bit <= previous_bit;
    end
  end

  `ASSERT_CLK(a_frame_wrap, clk, rst,
    accept && is_last |=> byte_position == '0 && nibble_sum == '0 && !previous_bit,
    "frame state not cleared after last byte")

endmodule

@@ src/ifpe_pair.sv @@
// Pair generator: walks the slots of the held byte and registers one
// mark/space pair per beat. Depends on ifpe_pkg and assert_macros.svh.
module ifpe_pair (
  input  logic                       clk,
  input  logic                       rst,
  input  ifpe_pkg::cfg_t             cfg,
  input  logic                       item_valid,
  input  ifpe_pkg::item_t            item,
  output logic                       item_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ifpe_pkg::DUR_W-1:0] mark_time,
  output logic [ifpe_pkg::DUR_W-1:0] space_time,
  output logic                       last_pulse,
  output logic                       frame_end
);
  import ifpe_pkg::*;
  `include "assert_macros.svh"

  logic [3:0]       slot;
  logic [3:0]       eff_slot;
  logic [3:0]       end_slot;
  logic             load;
  logic [2:0]       bit_idx;
  logic [2:0]       prev_idx;
  logic             cur_bit;
  logic             prev_bit;
  logic [SUM_W-1:0] mark_sum;
  logic [SUM_W-1:0] space_sum;
  logic [DUR_W-1:0] mark_next;
  logic [DUR_W-1:0] space_next;
  logic             last_next;
  logic             end_next;

  assign eff_slot  = (slot == SLOT_HEAD && !item.first) ? SLOT_BIT0 : slot;
  assign end_slot  = item.last ? SLOT_TRAIL : SLOT_BIT7;
  assign load      = item_valid && (!out_valid || out_ready);
  assign item_done = load && (eff_slot == end_slot);

  assign bit_idx  = 3'(eff_slot - SLOT_BIT0);
  assign prev_idx = bit_idx - 3'd1;
  assign cur_bit  = item.byte_val[bit_idx];
  assign prev_bit = (bit_idx == 3'd0) ? item.prev_bit : item.byte_val[prev_idx];

  always_comb begin
    mark_sum  = '0;
    space_sum = '0;
    last_next = 1'b0;
    end_next  = 1'b0;
    unique case (eff_slot)
      SLOT_HEAD: begin
        mark_sum  = SUM_W'(cfg.header_mark);
        space_sum = SUM_W'(cfg.header_space);
      end
      SLOT_FOOT: begin
        mark_sum  = SUM_W'(cfg.footer_mark);
        space_sum = SUM_W'(cfg.footer_space);
      end
      SLOT_TRAIL: begin
        mark_sum  = SUM_W'(cfg.header_mark);
        space_sum = SUM_W'(cfg.header_space);
        last_next = 1'b1;
        end_next  = 1'b1;
      end
      default: begin
        mark_sum  = SUM_W'(cur_bit ? cfg.one_mark : cfg.zero_mark)
                  + ((item.first && bit_idx == 3'd0) ? FIRST_MARK_BONUS : '0)
                  + (prev_bit ? AFTER_ONE_BONUS : '0);
        space_sum = SUM_W'(cur_bit ? cfg.one_space : cfg.zero_space)
                  + ((bit_idx[1:0] == 2'b11) ? NIBBLE_SPACE_BONUS : '0);
        last_next = (eff_slot == SLOT_BIT7) && !item.last;
      end
    endcase
  end

  assign mark_next  = mark_sum[DUR_W]  ? '1 : mark_sum[DUR_W-1:0];
  assign space_next = space_sum[DUR_W] ? '1 : space_sum[DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= SLOT_HEAD;
      out_valid <= 1'b0;
    end else begin
      if (item_done) begin
        slot <= SLOT_HEAD;
      end else if (load) begin
        slot <= eff_slot + 4'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mark_time  <= mark_next;
      space_time <= space_next;
      last_pulse <= last_next;
      frame_end  <= end_next;
    end
  end

  `ASSERT_CLK(a_end_is_last, clk, rst,
    out_valid && frame_end |-> last_pulse,
    "frame end without last pulse")
  `ASSERT_NEVER(a_slot_range, clk, rst,
    item_valid && slot > SLOT_TRAIL,
    "slot counter out of range")
  `ASSERT_CLK(a_trail_flags, clk, rst,
    item_done && item.last |=> out_valid && frame_end && last_pulse,
    "last byte did not close the frame")

endmodule

@@ src/ir_frame_pulse_encoder_unit.sv @@
// Top level of the IR frame pulse encoder: stream ports and configuration.
// Depends on ifpe_pkg, ifpe_cfg, ifpe_input and ifpe_pair.
//
// Each accepted frame byte becomes one mark/space pair per bit (LSB first),
// plus a header pair before byte zero and a footer and closing header pair
// after the last byte, whose upper nibble is replaced by the nibble checksum.
// One pair leaves per beat through the single output register, so byte zero
// gives nine pairs, middle bytes eight and the last byte ten. The next byte
// is taken in the cycle its predecessor's final pair is registered, so pairs
// stream without gaps while s_tvalid and m_tready stay high. Write configuration only
// while the block is idle.
module ir_frame_pulse_encoder_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] frame_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // [15:0] mark_time, [31:16] space_time
  output logic                       m_tlast,   // last_pulse
  output logic                       m_tuser,   // frame_end
  input  logic                       cfg_wen,
  input  logic [ifpe_pkg::IDX_W-1:0] cfg_index,
  input  logic [ifpe_pkg::DUR_W-1:0] cfg_wdata
);
  import ifpe_pkg::*;

  cfg_t             cfg;
  item_t            item;
  logic             item_valid;
  logic             item_done;
  logic [DUR_W-1:0] mark_time;
  logic [DUR_W-1:0] space_time;

  ifpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifpe_input u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .frame_byte (s_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_done  (item_done)
  );

  ifpe_pair u_pair (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_done  (item_done),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .mark_time  (mark_time),
    .space_time (space_time),
    .last_pulse (m_tlast),
    .frame_end  (m_tuser)
  );

  assign m_tdata = {space_time, mark_time};

endmodule

@@ verif/tb.sv @@
// Testbench for ir_frame_pulse_encoder_unit: directed frames, then random byte streams
// with register changes between bursts, all checked against an in-bench pair predictor.
// Depends on ifpe_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module tb;
  import ifpe_pkg::*;

  localparam int ITEMS_TARGET  = 420;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int DIR_ROWS      = 24;
  localparam int NOMINAL_AT    = 8;
  localparam int SATURATE_AT   = 16;

  typedef struct packed {
    logic [DUR_W-1:0] mark_time;
    logic [DUR_W-1:0] space_time;
    logic             last_pulse;
    logic             frame_end;
  } pulse_pair_t;

  typedef struct {
    logic [7:0]       frame_byte;
    bit               typed;      // every pair of this byte carries dur as mark and space
    logic [DUR_W-1:0] dur;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;
  logic             m_tlast;
  logic             m_tuser;
  logic             cfg_wen;
  logic [IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0] cfg_wdata;

  ir_frame_pulse_encoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [DUR_W-1:0] dur_reg [NREG];
  int               frame_pos = 0;
  logic [3:0]       nib_sum = 4'd0;
  logic             prev_bit = 1'b0;

  pulse_pair_t pairs_due [$];
  int          fails = 0;
  int          bytes_sent = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset registers (all zero)
    '{8'h00, 1'b0, 16'h0}, '{8'hFF, 1'b0, 16'h0}, '{8'h01, 1'b0, 16'h0},
    '{8'h80, 1'b0, 16'h0}, '{8'h5A, 1'b0, 16'h0}, '{8'hA5, 1'b0, 16'h0},
    '{8'h3C, 1'b0, 16'h0}, '{8'hC3, 1'b0, 16'h0},
    // nominal timings
    '{8'h00, 1'b0, 16'h0}, '{8'hFF, 1'b0, 16'h0}, '{8'h55, 1'b0, 16'h0},
    '{8'hAA, 1'b0, 16'h0}, '{8'h0F, 1'b0, 16'h0}, '{8'hF0, 1'b0, 16'h0},
    '{8'h01, 1'b0, 16'h0}, '{8'h8E, 1'b0, 16'h0},
    // all registers at full scale: every duration is all ones, saturating where a bonus adds
    '{8'hFF, 1'b1, 16'hFFFF}, '{8'h00, 1'b1, 16'hFFFF}, '{8'h7F, 1'b1, 16'hFFFF},
    '{8'hFE, 1'b1, 16'hFFFF}, '{8'h81, 1'b1, 16'hFFFF}, '{8'h18, 1'b1, 16'hFFFF},
    '{8'h66, 1'b1, 16'hFFFF}, '{8'h99, 1'b1, 16'hFFFF}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 37);
  endfunction

  function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W:0] v);
    return v[DUR_W] ? {DUR_W{1'b1}} : v[DUR_W-1:0];
  endfunction

  function automatic pulse_pair_t make_pair(input logic [DUR_W:0] mark, input logic [DUR_W:0] space,
                                            input logic lp, input logic fe);
    pulse_pair_t p;
    p.mark_time  = sat_dur(mark);
    p.space_time = sat_dur(space);
    p.last_pulse = lp;
    p.frame_end  = fe;
    return p;
  endfunction

  // pairs caused by one frame byte; advances the frame state
  function automatic void encode_byte(input logic [7:0] in_byte, output pulse_pair_t pairs [$]);
    logic [7:0]     b;
    logic [3:0]     lo;
    logic [3:0]     hi;
    logic [3:0]     csum;
    bit             first;
    bit             last;
    logic           bit_v;
    logic [DUR_W:0] mark;
    logic [DUR_W:0] space;
    pairs = {};
    b     = in_byte;
    lo    = b[3:0];
    hi    = b[7:4];
    csum  = nib_sum + lo;
    first = (frame_pos == 0);
    last  = (frame_pos >= FRAME_BYTES - 1);
    if (last) b = {csum, lo};
    if (first) begin
      pairs.push_back(make_pair({1'b0, dur_reg[REG_HEADER_MARK]},
                                {1'b0, dur_reg[REG_HEADER_SPACE]}, 1'b0, 1'b0));
    end
    for (int j = 0; j < 8; j++) begin
      bit_v = b[j];
      mark  = {1'b0, bit_v ? dur_reg[REG_ONE_MARK] : dur_reg[REG_ZERO_MARK]};
      space = {1'b0, bit_v ? dur_reg[REG_ONE_SPACE] : dur_reg[REG_ZERO_SPACE]};
      if (first && j == 0) mark = mark + FIRST_MARK_BONUS;
      if (j % 4 == 3) space = space + NIBBLE_SPACE_BONUS;
      if (prev_bit) mark = mark + AFTER_ONE_BONUS;
      pairs.push_back(make_pair(mark, space, !last && j == 7, 1'b0));
      prev_bit = bit_v;
    end
    if (last) begin
      pairs.push_back(make_pair({1'b0, dur_reg[REG_FOOTER_MARK]},
                                {1'b0, dur_reg[REG_FOOTER_SPACE]}, 1'b0, 1'b0));
      pairs.push_back(make_pair({1'b0, dur_reg[REG_HEADER_MARK]},
                                {1'b0, dur_reg[REG_HEADER_SPACE]}, 1'b1, 1'b1));
      frame_pos = 0;
      nib_sum   = 4'd0;
      prev_bit  = 1'b0;
    end else begin
      nib_sum   = nib_sum + lo + hi;
      frame_pos = frame_pos + 1;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input stim_row_t row);
    pulse_pair_t pairs [$];
    while (idle_now()) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = row.frame_byte;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_byte(row.frame_byte, pairs);
    foreach (pairs[k]) begin
      if (row.typed) begin
        pairs[k].mark_time  = row.dur;
        pairs[k].space_time = row.dur;
      end
      pairs_due.push_back(pairs[k]);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pairs_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_wen      = 1'b1;
    cfg_index    = idx;
    cfg_wdata    = val;
    dur_reg[idx] = val;
    @(negedge clk);
  endtask

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {DUR_W{1'b1}};
      2:       return DUR_W'(65000);
      default: return DUR_W'($urandom_range(0, 12000));
    endcase
  endfunction

  function automatic stim_row_t pick_row();
    stim_row_t row;
    row.typed = 1'b0;
    row.dur   = '0;
    case ($urandom_range(0, 7))
      0:       row.frame_byte = 8'h00;
      1:       row.frame_byte = 8'hFF;
      default: row.frame_byte = 8'($urandom_range(0, 255));
    endcase
    return row;
  endfunction

  always @(negedge clk) begin
    m_tready <= !idle_now();
  end

  always @(posedge clk) begin
    pulse_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pairs_due.size() == 0) begin
        fails++;
        $error("beat with no pair expected: tdata %h", m_tdata);
      end else begin
        want = pairs_due.pop_front();
        check_field("mark_time", want.mark_time, m_tdata[15:0]);
        check_field("space_time", want.space_time, m_tdata[31:16]);
        check_field("last_pulse", want.last_pulse, m_tlast);
        check_field("frame_end", want.frame_end, m_tuser);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int burst;
    foreach (dur_reg[i]) dur_reg[i] = '0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == NOMINAL_AT) begin
        drain();
        write_reg(REG_HEADER_MARK, 16'd9000);
        write_reg(REG_HEADER_SPACE, 16'd4500);
        write_reg(REG_ZERO_MARK, 16'd560);
        write_reg(REG_ZERO_SPACE, 16'd560);
        write_reg(REG_ONE_MARK, 16'd560);
        write_reg(REG_ONE_SPACE, 16'd1690);
        write_reg(REG_FOOTER_MARK, 16'd560);
        write_reg(REG_FOOTER_SPACE, 16'd20000);
        cfg_wen = 1'b0;
      end
      if (i == SATURATE_AT) begin
        drain();
        for (int r = 0; r < NREG; r++) write_reg(IDX_W'(r), 16'hFFFF);
        cfg_wen = 1'b0;
      end
      push_byte(dir_rows[i]);
    end

    // bursts of random length, so register changes also land mid-frame
    phase = 0;
    while (bytes_sent < ITEMS_TARGET) begin
      drain();
      calm = (phase >= 4 && phase < 7);
      for (int r = 0; r < NREG; r++) begin
        if ($urandom_range(0, 1)) write_reg(IDX_W'(r), pick_dur());
      end
      cfg_wen = 1'b0;
      burst = $urandom_range(1, 30);
      repeat (burst) push_byte(pick_row());
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
